### src/mprd_pkg.sv
// Shared types and constants for the mouse position to report delta block.
package mprd_pkg;

  localparam int unsigned POS_W        = 16;
  localparam int unsigned WHEEL_W      = 8;
  localparam int unsigned FLAG_W       = 8;
  localparam int unsigned BTN_W        = 5;
  localparam int unsigned FLAG_FIRST   = 7;
  localparam int unsigned FLAG_IGNORE  = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // One data packet after classification: deltas against the latched positions.
  typedef struct packed {
    logic [BTN_W-1:0]          buttons;
    logic signed [POS_W-1:0]   dx;
    logic signed [POS_W-1:0]   dy;
    logic signed [WHEEL_W-1:0] dw;
    logic                      pending;
  } delta_t;

  // Write side of the queue.
  typedef struct packed {
    logic   valid;
    delta_t data;
  } push_t;

  // Read side of the queue.
  typedef struct packed {
    logic   valid;
    delta_t data;
  } head_t;

endpackage

### src/mprd_front.sv
// Front end: classify packets, latch positions and form modular deltas.
module mprd_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mprd_pkg::POS_W-1:0]      pos_x_i,
  input  logic signed [mprd_pkg::POS_W-1:0]      pos_y_i,
  input  logic [mprd_pkg::FLAG_W-1:0]            flag_buttons_i,
  input  logic signed [mprd_pkg::WHEEL_W-1:0]    wheel_pos_i,
  input  logic                                   report_pending_i,
  input  logic                                   q_full_i,
  output mprd_pkg::push_t                        push_o
);
  import mprd_pkg::*;

  logic signed [POS_W-1:0]   last_x_q, last_x_d;
  logic signed [POS_W-1:0]   last_y_q, last_y_d;
  logic signed [WHEEL_W-1:0] last_wheel_q, last_wheel_d;
  logic                      accept;
  logic                      ignore_pkt;
  logic                      first_pkt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign ignore_pkt = flag_buttons_i[FLAG_IGNORE];
  assign first_pkt  = flag_buttons_i[FLAG_FIRST];

  always_comb begin
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    last_wheel_d = last_wheel_q;
    // Latch positions for first and data packets; drop ignored ones.
    if (accept && !ignore_pkt) begin
      last_x_d     = pos_x_i;
      last_y_d     = pos_y_i;
      last_wheel_d = wheel_pos_i;
    end
  end

  always_comb begin
    push_o.valid        = accept && !ignore_pkt && !first_pkt;
    push_o.data.buttons = flag_buttons_i[BTN_W-1:0];
    push_o.data.dx      = pos_x_i - last_x_q;
    push_o.data.dy      = last_y_q - pos_y_i;
    push_o.data.dw      = wheel_pos_i - last_wheel_q;
    push_o.data.pending = report_pending_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_wheel_q <= '0;
    end else begin
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      last_wheel_q <= last_wheel_d;
    end
  end

endmodule

### src/mprd_queue.sv
// Short queue of classified deltas between front and back.
module mprd_queue #(
  parameter int unsigned Depth = mprd_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mprd_pkg::push_t push_i,
  output logic            full_o,
  output mprd_pkg::head_t head_o,
  input  logic            pop_i
);
  import mprd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  delta_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o        = (cnt_q == CntW'(Depth));
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.data   = mem_q[rd_ptr_q];
  assign do_push       = push_i.valid && !full_o;
  assign do_pop        = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/mprd_back.sv
// Back end: accumulate the running report and hold the result register.
module mprd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mprd_pkg::head_t                     head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                send_report_o,
  output logic                                flush_request_o,
  output logic [mprd_pkg::BTN_W-1:0]          report_buttons_o,
  output logic signed [mprd_pkg::WHEEL_W-1:0] report_wheel_o,
  output logic signed [mprd_pkg::POS_W-1:0]   report_dx_o,
  output logic signed [mprd_pkg::POS_W-1:0]   report_dy_o
);
  import mprd_pkg::*;

  logic signed [POS_W-1:0]   sum_dx_q, sum_dx_d;
  logic signed [POS_W-1:0]   sum_dy_q, sum_dy_d;
  logic signed [WHEEL_W-1:0] sum_wheel_q, sum_wheel_d;
  logic [BTN_W-1:0]          sent_buttons_q;
  logic                      out_valid_q;
  logic                      send_q, send_d;
  logic                      flush_q;
  logic [BTN_W-1:0]          buttons_q;

  // Advance whenever the result register is empty or being taken.
  assign pop_o       = head_i.valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    // Restart from zero once the previous report went out.
    sum_dx_d    = (head_i.data.pending ? sum_dx_q : '0) + head_i.data.dx;
    sum_dy_d    = (head_i.data.pending ? sum_dy_q : '0) + head_i.data.dy;
    sum_wheel_d = (head_i.data.pending ? sum_wheel_q : '0) + head_i.data.dw;
    send_d      = (head_i.data.buttons != sent_buttons_q) || (sum_dx_d != '0) ||
                  (sum_dy_d != '0) || (sum_wheel_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_dx_q       <= '0;
      sum_dy_q       <= '0;
      sum_wheel_q    <= '0;
      sent_buttons_q <= '0;
      out_valid_q    <= 1'b0;
    end else if (pop_o) begin
      sum_dx_q    <= sum_dx_d;
      sum_dy_q    <= sum_dy_d;
      sum_wheel_q <= sum_wheel_d;
      out_valid_q <= 1'b1;
      if (send_d) begin
        sent_buttons_q <= head_i.data.buttons;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      send_q    <= send_d;
      flush_q   <= head_i.data.pending;
      buttons_q <= head_i.data.buttons;
    end
  end

  assign send_report_o    = send_q;
  assign flush_request_o  = flush_q;
  assign report_buttons_o = buttons_q;
  assign report_wheel_o   = sum_wheel_q;
  assign report_dx_o      = sum_dx_q;
  assign report_dy_o      = sum_dy_q;

endmodule

### src/mouse_position_to_report_delta_core.sv
// Top level of the mouse position to report delta converter.
// Usage:
//   Input channel: one received mouse packet per transfer (pos_x_i, pos_y_i,
//   flag_buttons_i, wheel_pos_i, report_pending_i), qualified by in_valid_i
//   and held off by in_stall_o. A transfer happens at a clock edge with valid
//   high and stall low.
//   Output channel: one report per data packet (send_report_o, flush_request_o
//   and the report fields), qualified by out_valid_o and held by out_stall_i.
//   Ignore-flagged packets and first-flagged packets produce no report; first
//   packets only latch the absolute positions.
// Throughput, while out_stall_i is low: one packet per cycle. The front end
//   forms the deltas combinationally into a two-entry queue, and the back end
//   adds one queue entry per cycle to the running sums and result register.
// Path: a data packet is written into the queue at its transfer, then
//   accumulated from the queue head into the result register, which drives
//   the report outputs.
// Reset: rst_ni clears the latched positions, the running sums, the sent
//   button state and the queue; no report is valid after reset.
// Stall: while out_stall_i holds a valid report, the result register and
//   its fields hold; the queue fills, and in_stall_o rises only when full.
module mouse_position_to_report_delta_core #(
  parameter int unsigned QueueDepth = mprd_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mprd_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [mprd_pkg::POS_W-1:0]   pos_y_i,
  input  logic [mprd_pkg::FLAG_W-1:0]         flag_buttons_i,
  input  logic signed [mprd_pkg::WHEEL_W-1:0] wheel_pos_i,
  input  logic                                report_pending_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                send_report_o,
  output logic                                flush_request_o,
  output logic [mprd_pkg::BTN_W-1:0]          report_buttons_o,
  output logic signed [mprd_pkg::WHEEL_W-1:0] report_wheel_o,
  output logic signed [mprd_pkg::POS_W-1:0]   report_dx_o,
  output logic signed [mprd_pkg::POS_W-1:0]   report_dy_o
);
  import mprd_pkg::*;

  push_t q_push;
  head_t q_head;
  logic  q_full;
  logic  q_pop;

  // Classify the packet and form the deltas against the latched positions.
  mprd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .flag_buttons_i   (flag_buttons_i),
    .wheel_pos_i      (wheel_pos_i),
    .report_pending_i (report_pending_i),
    .q_full_i         (q_full),
    .push_o           (q_push)
  );

  // Decouple the front from output backpressure.
  mprd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  // Accumulate the running report and present it.
  mprd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (q_head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .send_report_o    (send_report_o),
    .flush_request_o  (flush_request_o),
    .report_buttons_o (report_buttons_o),
    .report_wheel_o   (report_wheel_o),
    .report_dx_o      (report_dx_o),
    .report_dy_o      (report_dy_o)
  );

`ifndef SYNTHESIS
  // A report that is not sent carries all-zero sums.
  a_idle_report_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_report_o |->
      report_dx_o == '0 && report_dy_o == '0 && report_wheel_o == '0)
    else $error("unsent report with nonzero sums");

  // Ignored packets never reach the queue.
  a_ignore_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && flag_buttons_i[FLAG_IGNORE] |-> !q_push.valid)
    else $error("ignored packet entered the queue");

  // A queue pop always lands in the result register.
  a_pop_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("popped entry did not produce a report");
`endif

endmodule

### tb/mouse_position_to_report_delta_core_test.sv
// Self-checking testbench for the mouse position to report delta converter.
module mouse_position_to_report_delta_core_test;
  import mprd_pkg::*;

  // The sync flag is carried by the packet but has no effect on the block.
  localparam int unsigned FLAG_SYNC = 6;
  localparam int unsigned HOLD_CYCLES = 48;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [FLAG_W-1:0]  flags;
    logic [WHEEL_W-1:0] wheel;
    logic               pending;
  } mouse_pkt_t;

  typedef struct packed {
    logic               send;
    logic               flush;
    logic [BTN_W-1:0]   buttons;
    logic [WHEEL_W-1:0] wheel;
    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
  } report_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [POS_W-1:0]   pos_x_i = '0;
  logic signed [POS_W-1:0]   pos_y_i = '0;
  logic [FLAG_W-1:0]         flag_buttons_i = '0;
  logic signed [WHEEL_W-1:0] wheel_pos_i = '0;
  logic                      report_pending_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      send_report_o;
  logic                      flush_request_o;
  logic [BTN_W-1:0]          report_buttons_o;
  logic signed [WHEEL_W-1:0] report_wheel_o;
  logic signed [POS_W-1:0]   report_dx_o;
  logic signed [POS_W-1:0]   report_dy_o;

  mouse_position_to_report_delta_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .flag_buttons_i   (flag_buttons_i),
    .wheel_pos_i      (wheel_pos_i),
    .report_pending_i (report_pending_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .send_report_o    (send_report_o),
    .flush_request_o  (flush_request_o),
    .report_buttons_o (report_buttons_o),
    .report_wheel_o   (report_wheel_o),
    .report_dx_o      (report_dx_o),
    .report_dy_o      (report_dy_o)
  );

  always #2 clk_i = ~clk_i;

  // Packets waiting to be offered, and reports that the block still owes us.
  mouse_pkt_t packet_q[$];
  report_t    report_q[$];
  mouse_pkt_t offered = '0;

  // Idle and stall odds in percent; changed only between clock edges.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned err_cnt = 0;

  // Predictor state: latched absolute counters and the running report.
  logic [POS_W-1:0]   seen_x = '0;
  logic [POS_W-1:0]   seen_y = '0;
  logic [WHEEL_W-1:0] seen_wheel = '0;
  logic [POS_W-1:0]   acc_dx = '0;
  logic [POS_W-1:0]   acc_dy = '0;
  logic [WHEEL_W-1:0] acc_wheel = '0;
  logic [BTN_W-1:0]   sent_btn = '0;

  // Fold one accepted packet into the running report and queue the report it causes.
  task automatic predict_report(input mouse_pkt_t p);
    report_t            r;
    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
    logic [WHEEL_W-1:0] dw;
    logic [BTN_W-1:0]   btn;
    // Drop ignored packets outright, even when the first flag rides along.
    if (p.flags[FLAG_IGNORE]) return;
    if (p.flags[FLAG_FIRST]) begin
      // First packet: latch the counters, report nothing.
      seen_x = p.pos_x;
      seen_y = p.pos_y;
      seen_wheel = p.wheel;
      return;
    end
    btn = p.flags[BTN_W-1:0];
    dx = p.pos_x - seen_x;
    dy = seen_y - p.pos_y;   // y axis is inverted
    dw = p.wheel - seen_wheel;
    seen_x = p.pos_x;
    seen_y = p.pos_y;
    seen_wheel = p.wheel;
    // Restart the sums once the previous report went out; keep adding if it is stale.
    if (!p.pending) begin
      acc_dx = '0;
      acc_dy = '0;
      acc_wheel = '0;
    end
    acc_dx = acc_dx + dx;
    acc_dy = acc_dy + dy;
    acc_wheel = acc_wheel + dw;
    r.send = (btn != sent_btn) || (acc_wheel != '0) || (acc_dx != '0) || (acc_dy != '0);
    if (r.send) sent_btn = btn;
    r.flush = p.pending;
    r.buttons = btn;
    r.wheel = acc_wheel;
    r.dx = acc_dx;
    r.dy = acc_dy;
    report_q.push_back(r);
  endtask

  // Driver: account for the transfer that just happened, then advance or hold the offer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pos_x_i <= '0;
      pos_y_i <= '0;
      flag_buttons_i <= '0;
      wheel_pos_i <= '0;
      report_pending_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_report(offered);
      // Hold a stalled payload; otherwise pick the next packet or go idle.
      if (!in_valid_i || !in_stall_o) begin
        if (packet_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered <= packet_q[0];
          pos_x_i <= packet_q[0].pos_x;
          pos_y_i <= packet_q[0].pos_y;
          flag_buttons_i <= packet_q[0].flags;
          wheel_pos_i <= packet_q[0].wheel;
          report_pending_i <= packet_q[0].pending;
          in_valid_i <= 1'b1;
          void'(packet_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: check each transferred report against the oldest prediction, then
  // decide the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    report_t r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected report, expected none, got send %b dx %0h dy %0h",
                   $time, send_report_o, report_dx_o, report_dy_o);
        end else begin
          r = report_q.pop_front();
          check_field("send_report", 32'(r.send), 32'(send_report_o));
          check_field("flush_request", 32'(r.flush), 32'(flush_request_o));
          check_field("report_buttons", 32'(r.buttons), 32'(report_buttons_o));
          check_field("report_wheel", 32'(r.wheel), 32'($unsigned(report_wheel_o)));
          check_field("report_dx", 32'(r.dx), 32'($unsigned(report_dx_o)));
          check_field("report_dy", 32'(r.dy), 32'($unsigned(report_dy_o)));
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing into a full block.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic mouse_pkt_t make_pkt(input logic [15:0] x, input logic [15:0] y,
                                          input logic [7:0] fl, input logic [7:0] w,
                                          input logic pend);
    mouse_pkt_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.flags = fl;
    p.wheel = w;
    p.pending = pend;
    return p;
  endfunction

  // Stimulus generator state: where the simulated mouse currently is.
  logic [POS_W-1:0]   walk_x = '0;
  logic [POS_W-1:0]   walk_y = '0;
  logic [WHEEL_W-1:0] walk_w = '0;
  logic [BTN_W-1:0]   walk_btn = '0;

  // Build one random packet; return 1 when it is not an ignored one.
  task automatic add_random_packet(output bit counted);
    logic [FLAG_W-1:0] fl;
    int unsigned       kind;
    int unsigned       move;
    kind = $urandom_range(99);
    fl = FLAG_W'($urandom);
    counted = 1'b1;
    if (kind < 5) begin
      // Noise: ignored packet with arbitrary content.
      fl[FLAG_IGNORE] = 1'b1;
      packet_q.push_back(make_pkt(16'($urandom), 16'($urandom), fl, 8'($urandom),
                                  1'($urandom_range(1))));
      counted = 1'b0;
    end else if (kind < 10) begin
      // Resync: a first packet jumps the counters anywhere.
      fl[FLAG_IGNORE] = 1'b0;
      fl[FLAG_FIRST] = 1'b1;
      walk_x = POS_W'($urandom);
      walk_y = POS_W'($urandom);
      walk_w = WHEEL_W'($urandom);
      packet_q.push_back(make_pkt(walk_x, walk_y, fl, walk_w, 1'($urandom_range(1))));
    end else begin
      move = $urandom_range(9);
      if (move >= 3 && move <= 8) begin
        walk_x = walk_x + POS_W'($urandom_range(30)) - POS_W'(15);
        walk_y = walk_y + POS_W'($urandom_range(30)) - POS_W'(15);
        walk_w = walk_w + WHEEL_W'($urandom_range(4)) - WHEEL_W'(2);
      end else if (move == 9) begin
        walk_x = POS_W'($urandom);
        walk_y = POS_W'($urandom);
        walk_w = WHEEL_W'($urandom);
      end
      // Keep the buttons mostly steady so that quiet packets send nothing.
      if ($urandom_range(3) == 0) walk_btn = BTN_W'($urandom);
      fl[FLAG_FIRST] = 1'b0;
      fl[FLAG_IGNORE] = 1'b0;
      fl[BTN_W-1:0] = walk_btn;
      packet_q.push_back(make_pkt(walk_x, walk_y, fl, walk_w, 1'($urandom_range(1))));
    end
  endtask

  task automatic wait_offered_all;
    while (packet_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  localparam logic [7:0] F_FIRST  = 8'h1 << FLAG_FIRST;
  localparam logic [7:0] F_IGNORE = 8'h1 << FLAG_IGNORE;
  localparam logic [7:0] F_SYNC   = 8'h1 << FLAG_SYNC;
  localparam logic [7:0] F_BTNS   = 8'h1F;

  int unsigned idle_tab[4]  = '{0, 83, 0, 21};
  int unsigned stall_tab[4] = '{0, 0, 83, 21};

  initial begin
    int unsigned n;
    bit          counted;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed packets, sent back to back with a ready receiver.
    // Quiet data right after reset: nothing moved, no buttons, so nothing to send.
    packet_q.push_back(make_pkt(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0));
    // Latch the positive extremes, then step across the wrap point.
    packet_q.push_back(make_pkt(16'h7FFF, 16'h7FFF, F_FIRST, 8'h7F, 1'b0));
    packet_q.push_back(make_pkt(16'h8000, 16'h8000, F_BTNS, 8'h80, 1'b0));
    // Ignore wins over first; neither may touch the latched positions.
    packet_q.push_back(make_pkt(16'h1234, 16'h5678, F_IGNORE | F_FIRST | F_BTNS, 8'h33, 1'b1));
    packet_q.push_back(make_pkt(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0));
    packet_q.push_back(make_pkt(16'h0001, 16'h0001, F_IGNORE, 8'h01, 1'b1));
    // Unchanged position and buttons: nothing to send, with and without a stale one.
    packet_q.push_back(make_pkt(16'h8000, 16'h8000, F_BTNS, 8'h80, 1'b0));
    packet_q.push_back(make_pkt(16'h8000, 16'h8000, F_SYNC | F_BTNS, 8'h80, 1'b1));
    // Full-scale moves, then keep accumulating while the report stays pending.
    packet_q.push_back(make_pkt(16'h7FFF, 16'h0000, 8'h00, 8'h7F, 1'b0));
    packet_q.push_back(make_pkt(16'h0000, 16'h7FFF, 8'h00, 8'h00, 1'b1));
    packet_q.push_back(make_pkt(16'h8000, 16'h8000, 8'h00, 8'h80, 1'b1));
    packet_q.push_back(make_pkt(16'h7FFF, 16'h7FFF, F_SYNC, 8'h7F, 1'b1));
    packet_q.push_back(make_pkt(16'h8000, 16'h8000, 8'h00, 8'h80, 1'b1));
    // Resync with stray button and sync bits set, then button-only changes.
    packet_q.push_back(make_pkt(16'h0000, 16'h0000, F_FIRST | F_SYNC | F_BTNS, 8'h00, 1'b1));
    packet_q.push_back(make_pkt(16'h0000, 16'h0000, 8'h0A, 8'h00, 1'b0));
    packet_q.push_back(make_pkt(16'h0000, 16'h0000, 8'h15, 8'h00, 1'b1));
    packet_q.push_back(make_pkt(16'h0000, 16'h0000, 8'h15, 8'h00, 1'b0));
    // Single-count steps and the negative extremes.
    packet_q.push_back(make_pkt(16'h0000, 16'h0001, 8'h15, 8'hFF, 1'b0));
    packet_q.push_back(make_pkt(16'hFFFF, 16'h0001, 8'h15, 8'hFF, 1'b1));
    packet_q.push_back(make_pkt(16'h8000, 16'h7FFF, 8'h00, 8'h80, 1'b0));
    packet_q.push_back(make_pkt(16'h7FFF, 16'h8000, 8'h1F, 8'h7F, 1'b1));
    wait_offered_all();

    // Random phases; the first one also carries the long receiver hold-off.
    walk_x = 16'h7FFF;
    walk_y = 16'h8000;
    walk_w = 8'h7F;
    walk_btn = 5'h1F;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) hold_go = 1'b1;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        add_random_packet(counted);
        if (counted) n++;
      end
      wait_offered_all();
    end

    // Drain every owed report, then watch a little longer for strays.
    while (report_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("PASS mouse_position_to_report_delta_core");
    else
      $display("FAIL mouse_position_to_report_delta_core");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL mouse_position_to_report_delta_core");
    $finish;
  end

endmodule

### filelist.f
src/mprd_pkg.sv
src/mprd_front.sv
src/mprd_queue.sv
src/mprd_back.sv
src/mouse_position_to_report_delta_core.sv
tb/mouse_position_to_report_delta_core_test.sv
